[rtl/core/bitmap_page_allocator_top_macros.svh]
// assertion macros for the bitmap page allocator
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define BPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpa check failed");

// next-cycle implication, checked outside reset
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpa check failed");

`endif

[rtl/core/bpa_pkg.sv]
// shared types and constants of the bitmap page allocator
package bpa_pkg;
    localparam int WORD_W    = 64;
    localparam int PAGE_W    = 12;
    localparam int CNT_W     = 13;
    localparam int MAX_PAGES = 4096;

    typedef enum logic [2:0] {
        OP_ALLOC_ONE = 3'd0,
        OP_ALLOC_RUN = 3'd1,
        OP_FREE_RUN  = 3'd2,
        OP_MARK_FREE = 3'd3,
        OP_MARK_USED = 3'd4
    } op_t;
endpackage

[rtl/core/bpa_ram.sv]
// generic single-port-write, registered-read ram
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/bitmap_page_allocator_top.sv]
// Bitmap page allocator top level: first-fit search over a word-wide usage map.
// Free and mark read and rewrite each map word touched (S_WRD, S_WMOD); allocations scan
// the map word by word (S_SRD, S_SLD, S_SCAN), skipping fully used words and checking words with
// free pages 8 pages a cycle, then write back each word of the run (S_WRD, S_WMOD) and finish in S_DONE.
// One operation at a time; busy is high until the done strobe; no output stall.
// Reset (async, active low) marks every page used, clears the count, page_count = 4096.
module bitmap_page_allocator_top #(
    parameter int NUM_PAGES = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   opcode,
    input  logic [bpa_pkg::PAGE_W-1:0]   run_start,
    input  logic [bpa_pkg::CNT_W-1:0]    run_length,
    output logic                         done,
    output logic [bpa_pkg::PAGE_W-1:0]   page_index,
    output logic                         ok,
    output logic [bpa_pkg::CNT_W-1:0]    used_count,
    input  logic                         cfg_we,
    input  logic [bpa_pkg::CNT_W-1:0]    cfg_data
);
    import bpa_pkg::*;

    localparam int EFF_PAGES = (NUM_PAGES < MAX_PAGES) ? NUM_PAGES : MAX_PAGES;
    localparam int MAP_WORDS = (EFF_PAGES + WORD_W - 1) / WORD_W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SRD, S_SLD, S_SCAN, S_WRD, S_WMOD, S_DONE
    } state_t;

    state_t             state_reg;
    logic [2:0]         op_reg;
    logic [CNT_W-1:0]   len_reg;
    logic [CNT_W-1:0]   pc_reg;
    logic [CNT_W-1:0]   page_count_reg;
    logic [CNT_W-1:0]   used_reg;
    logic [CNT_W-1:0]   run_reg;
    logic [AW-1:0]      wa_reg;
    logic [2:0]         chunk_reg;
    logic [WORD_W-1:0]  word_reg;
    logic [PAGE_W-1:0]  first_reg;
    logic [PAGE_W-1:0]  last_reg;
    logic               ok_reg;
    logic [MAP_WORDS-1:0] valid_reg;
    logic               done_reg;
    logic [PAGE_W-1:0]  page_index_reg;
    logic               res_ok_reg;
    logic [CNT_W-1:0]   used_count_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_W-1:0]  ram_rdata;
    logic [WORD_W-1:0]  eff_word;

    // effective page count of the current register value
    logic [CNT_W-1:0]   pc_now;
    assign pc_now = (page_count_reg < CNT_W'(EFF_PAGES)) ? page_count_reg : CNT_W'(EFF_PAGES);

    // map word storage
    bpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wa_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a word never written reads as all used
    assign eff_word = valid_reg[wa_reg] ? ram_rdata : {WORD_W{1'b1}};

    // read address follows the word address register
    always_comb
    begin
        ram_raddr = wa_reg;
    end

    // eight-page run tracking for one chunk of the scanned word
    logic [CNT_W-1:0]   run_v;
    logic               found_v;
    logic [PAGE_W-1:0]  end_v;
    always_comb
    begin
        logic [5:0]        pos;
        logic [PAGE_W-1:0] pg;
        logic              busy_bit;
        run_v   = run_reg;
        found_v = 1'b0;
        end_v   = '0;
        for (int b = 0; b < 8; b++)
        begin
            pos      = {chunk_reg, 3'(b)};
            pg       = PAGE_W'({wa_reg, pos});
            busy_bit = word_reg[pos] || (pg == '0) || ({1'b0, pg} >= pc_reg);
            if (!found_v)
            begin
                if (busy_bit)
                begin
                    run_v = '0;
                end
                else
                begin
                    run_v = run_v + 1'b1;
                    if (run_v == len_reg)
                    begin
                        found_v = 1'b1;
                        end_v   = pg;
                    end
                end
            end
        end
    end

    // first page of a found run
    logic [PAGE_W-1:0] first_v;
    assign first_v = PAGE_W'({1'b0, end_v} + 1'b1 - len_reg);

    // range mask and modified word for the write-back pass
    logic [5:0]        lo_bit;
    logic [5:0]        hi_bit;
    logic [WORD_W-1:0] range_mask;
    logic              set_bits;
    always_comb
    begin
        lo_bit     = (wa_reg == first_reg[AW+5:6]) ? first_reg[5:0] : 6'd0;
        hi_bit     = (wa_reg == last_reg[AW+5:6]) ? last_reg[5:0] : 6'd63;
        range_mask = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (6'd63 - hi_bit));
        set_bits   = (op_reg == OP_ALLOC_ONE) || (op_reg == OP_ALLOC_RUN)
                  || (op_reg == OP_MARK_USED);
        ram_wdata  = set_bits ? (eff_word | range_mask) : (eff_word & ~range_mask);
        ram_we     = (state_reg == S_WMOD);
    end

    // counter update at the end of an operation
    logic [CNT_W:0]    sum_v;
    logic [CNT_W-1:0]  used_new;
    always_comb
    begin
        sum_v    = {1'b0, used_reg} + {1'b0, len_reg};
        used_new = used_reg;
        if (ok_reg)
        begin
            if ((op_reg == OP_ALLOC_ONE) || (op_reg == OP_ALLOC_RUN))
            begin
                if (used_reg < pc_reg)
                begin
                    used_new = (sum_v > {1'b0, pc_reg}) ? pc_reg : sum_v[CNT_W-1:0];
                end
            end
            else if (op_reg == OP_FREE_RUN)
            begin
                used_new = (used_reg > len_reg) ? (used_reg - len_reg) : '0;
            end
        end
    end

    // argument check for free and mark
    logic [CNT_W:0] run_end;
    assign run_end = {2'b00, run_start} + {1'b0, run_length};

    // sequencer, counter and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            page_count_reg <= CNT_W'(MAX_PAGES);
            used_reg       <= '0;
            valid_reg      <= '0;
            done_reg       <= 1'b0;
            ok_reg         <= 1'b0;
            op_reg         <= '0;
            len_reg        <= '0;
            pc_reg         <= '0;
            run_reg        <= '0;
            wa_reg         <= '0;
            chunk_reg      <= '0;
            first_reg      <= '0;
            last_reg       <= '0;
            page_index_reg <= '0;
            res_ok_reg     <= 1'b0;
            used_count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                page_count_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg    <= opcode;
                        pc_reg    <= pc_now;
                        ok_reg    <= 1'b0;
                        run_reg   <= '0;
                        wa_reg    <= '0;
                        chunk_reg <= '0;
                        first_reg <= run_start;
                        last_reg  <= PAGE_W'(run_end - 1'b1);
                        priority if (opcode == OP_ALLOC_ONE)
                        begin
                            len_reg   <= CNT_W'(1);
                            state_reg <= S_SRD;
                        end
                        else if (opcode == OP_ALLOC_RUN)
                        begin
                            len_reg   <= run_length;
                            state_reg <= (run_length != '0 && run_length <= pc_now)
                                         ? S_SRD : S_DONE;
                        end
                        else if (opcode == OP_FREE_RUN || opcode == OP_MARK_FREE
                                 || opcode == OP_MARK_USED)
                        begin
                            len_reg <= run_length;
                            wa_reg  <= run_start[AW+5:6];
                            if (run_length != '0 && run_end <= {1'b0, pc_now})
                            begin
                                ok_reg    <= 1'b1;
                                state_reg <= S_WRD;
                            end
                            else
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        else
                        begin
                            len_reg   <= '0;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SRD:
                begin
                    state_reg <= S_SLD;
                end
                S_SLD:
                begin
                    chunk_reg <= '0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (chunk_reg == 3'd0 && word_reg == {WORD_W{1'b1}})
                    begin
                        run_reg <= '0;
                        if (wa_reg == LAST_WORD)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            wa_reg    <= wa_reg + 1'b1;
                            state_reg <= S_SRD;
                        end
                    end
                    else if (found_v)
                    begin
                        ok_reg    <= 1'b1;
                        first_reg <= first_v;
                        last_reg  <= end_v;
                        wa_reg    <= first_v[AW+5:6];
                        state_reg <= S_WRD;
                    end
                    else
                    begin
                        run_reg   <= run_v;
                        chunk_reg <= chunk_reg + 1'b1;
                        if (chunk_reg == 3'd7)
                        begin
                            if (wa_reg == LAST_WORD)
                            begin
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                wa_reg    <= wa_reg + 1'b1;
                                state_reg <= S_SRD;
                            end
                        end
                    end
                end
                S_WRD:
                begin
                    state_reg <= S_WMOD;
                end
                S_WMOD:
                begin
                    valid_reg[wa_reg] <= 1'b1;
                    if (wa_reg == last_reg[AW+5:6])
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        wa_reg    <= wa_reg + 1'b1;
                        state_reg <= S_WRD;
                    end
                end
                S_DONE:
                begin
                    used_reg       <= used_new;
                    used_count_reg <= used_new;
                    res_ok_reg     <= ok_reg;
                    page_index_reg <= (ok_reg && ((op_reg == OP_ALLOC_ONE)
                                      || (op_reg == OP_ALLOC_RUN))) ? first_reg : '0;
                    done_reg       <= 1'b1;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // scanned word holds no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SLD)
        begin
            word_reg <= eff_word;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign ok         = res_ok_reg;
    assign page_index = page_index_reg;
    assign used_count = used_count_reg;
endmodule

[rtl/core/bpa_checker.sv]
// port-level checks of the bitmap page allocator and their binding
`include "bitmap_page_allocator_top_macros.svh"

module bpa_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic                       ok,
    input logic [bpa_pkg::PAGE_W-1:0] page_index
);
    import bpa_pkg::*;

    // an accepted word keeps the block busy
    `BPA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // a result strobe lasts one cycle
    `BPA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    // failed operations report page zero
    `BPA_ASSERT_IMPL(a_fail_zero, clk, rst_n, done && !ok, page_index == '0)
    // results only come out once the block has gone idle
    `BPA_ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy)
endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .ok         (ok),
    .page_index (page_index)
);

[bench/tb_bitmap_page_allocator_top.sv]
// self-checking bench for the bitmap page allocator top level
module tb_bitmap_page_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bpa_pkg::*;

    localparam int NPAGES = 4096;
    localparam int MAX_CYCLES = 8000000;

    // operation codes outside the package enum
    localparam logic [2:0] OP_RSVD_5 = 3'd5;
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    // one result word as seen on the ports
    typedef struct packed {
        logic [PAGE_W-1:0] page_index;
        logic              ok;
        logic [CNT_W-1:0]  used_count;
    } alloc_result_t;

    // model of the map and counter plus a queue of pending results
    class alloc_scoreboard;
        bit            page_used[NPAGES];
        int            used_pages;
        int            page_limit;
        alloc_result_t pending[$];
        int            errors;
        int            checked;
        int            n_ok;

        function void clear();
            foreach (page_used[i]) page_used[i] = 1'b1;
            used_pages = 0;
            page_limit = NPAGES;
            errors = 0;
            checked = 0;
            n_ok = 0;
        endfunction

        function void set_limit(int v);
            page_limit = (v < NPAGES) ? v : NPAGES;
        endfunction

        // predict the outcome of one accepted command word
        function void note_command(logic [2:0] op, int first, int len);
            alloc_result_t r;
            int hit;
            int span;
            r = '0;
            hit = 0;
            if (op == OP_ALLOC_ONE) begin
                for (int i = 1; i < page_limit; i++) begin
                    if (!page_used[i]) begin
                        page_used[i] = 1'b1;
                        if (used_pages < page_limit) used_pages++;
                        r.page_index = PAGE_W'(i);
                        r.ok = 1'b1;
                        break;
                    end
                end
            end else if (op == OP_ALLOC_RUN) begin
                if (len != 0 && len <= page_limit) begin
                    span = 0;
                    for (int i = 1; i < page_limit; i++) begin
                        if (page_used[i]) begin
                            span = 0;
                            continue;
                        end
                        span++;
                        if (span == len) begin
                            hit = i + 1 - len;
                            for (int k = hit; k <= i; k++) begin
                                page_used[k] = 1'b1;
                                if (used_pages < page_limit) used_pages++;
                            end
                            r.page_index = PAGE_W'(hit);
                            r.ok = 1'b1;
                            break;
                        end
                    end
                end
            end else if (op == OP_FREE_RUN || op == OP_MARK_FREE || op == OP_MARK_USED) begin
                if (len != 0 && first + len <= page_limit) begin
                    for (int i = first; i < first + len; i++) begin
                        page_used[i] = (op == OP_MARK_USED);
                        if (op == OP_FREE_RUN && used_pages > 0) used_pages--;
                    end
                    r.ok = 1'b1;
                end
            end
            r.used_count = CNT_W'(used_pages);
            pending.push_back(r);
        endfunction

        // compare one strobed result with the oldest prediction
        function void check_result(alloc_result_t got);
            alloc_result_t exp;
            checked++;
            if (pending.size() == 0) begin
                $error("unexpected result word page_index=%0d ok=%0d used_count=%0d",
                       got.page_index, got.ok, got.used_count);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (exp.ok) n_ok++;
            if (got.page_index !== exp.page_index) begin
                $error("page_index expected %0d actual %0d", exp.page_index, got.page_index);
                errors++;
            end
            if (got.ok !== exp.ok) begin
                $error("ok expected %0d actual %0d", exp.ok, got.ok);
                errors++;
            end
            if (got.used_count !== exp.used_count) begin
                $error("used_count expected %0d actual %0d", exp.used_count, got.used_count);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [2:0]        opcode;
    logic [PAGE_W-1:0] run_start;
    logic [CNT_W-1:0]  run_length;
    logic              done;
    logic [PAGE_W-1:0] page_index;
    logic              ok;
    logic [CNT_W-1:0]  used_count;
    logic              cfg_we;
    logic [CNT_W-1:0]  cfg_data;

    alloc_scoreboard sb;
    int cycle_count;
    int burst_left;

    bitmap_page_allocator_top #(.NUM_PAGES(NPAGES)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .run_start(run_start), .run_length(run_length),
        .done(done), .page_index(page_index), .ok(ok), .used_count(used_count),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // result capture, sampled at the edge that ends the strobe cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result('{page_index, ok, used_count});
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("bitmap_page_allocator_top test failed");
            $finish;
        end
    end

    // issue one command word, with sender bursts and gaps
    task automatic send_word(logic [2:0] op, int first, int len);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        start      <= 1'b1;
        opcode     <= op;
        run_start  <= first[PAGE_W-1:0];
        run_length <= len[CNT_W-1:0];
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_command(op, first, len);
    endtask

    // wait for the block to drain, then write page_count
    task automatic write_limit(int v);
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v[CNT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_limit(v);
    endtask

    // one random word weighted toward well-formed boot and alloc traffic
    task automatic random_word();
        int sel;
        int pl;
        int len;
        int first;
        pl = sb.page_limit;
        sel = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 24);
        first = $urandom_range(0, 4095);
        if ($urandom_range(0, 3) != 0 && pl > 1) begin
            first = $urandom_range(0, pl - 1);
            if (first + len > pl) len = pl - first;
            if (len == 0) len = 1;
        end
        if (sel < 30)
            send_word(OP_ALLOC_ONE, first, len);
        else if (sel < 50)
            send_word(OP_ALLOC_RUN, first, len);
        else if (sel < 70)
            send_word(OP_FREE_RUN, first, len);
        else if (sel < 85)
            send_word(OP_MARK_FREE, first, len);
        else if (sel < 96)
            send_word(OP_MARK_USED, first, len);
        else
            send_word(3'($urandom_range(5, 7)), first, len);
    endtask

    initial
    begin
        int limits[6];
        sb = new();
        sb.clear();
        cycle_count = 0;
        burst_left  = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        opcode     = '0;
        run_start  = '0;
        run_length = '0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset map is all used, load a boot map, then edge cases
        send_word(OP_ALLOC_ONE, 0, 0);
        send_word(OP_ALLOC_RUN, 0, 0);
        send_word(OP_FREE_RUN, 0, 0);
        send_word(OP_MARK_FREE, 4095, 2);
        send_word(OP_MARK_FREE, 0, 4096);
        send_word(OP_ALLOC_ONE, 0, 0);
        send_word(OP_ALLOC_RUN, 0, 4096);
        send_word(OP_ALLOC_RUN, 0, 4095);
        send_word(OP_ALLOC_RUN, 0, 8191);
        send_word(OP_FREE_RUN, 4095, 1);
        send_word(OP_FREE_RUN, 0, 4096);
        send_word(OP_FREE_RUN, 0, 4096);
        send_word(OP_MARK_USED, 0, 4096);
        send_word(OP_MARK_FREE, 100, 50);
        send_word(OP_ALLOC_RUN, 0, 50);
        send_word(OP_ALLOC_ONE, 0, 0);
        send_word(OP_RSVD_5, 4095, 8191);
        send_word(OP_RSVD_7, 0, 1);
        send_word(OP_RSVD_6, 2730, 5461);
        send_word(OP_MARK_FREE, 1365, 2730);

        // random phases across several page_count settings
        limits = '{1, 0, 4096, 8191, 200, 70};
        foreach (limits[p]) begin
            write_limit(limits[p]);
            send_word(OP_MARK_FREE, 0, (limits[p] < 4096) ? limits[p] : 4096);
            for (int n = 0; n < 230; n++) random_word();
        end

        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d result words, %0d successful, over six page_count settings",
                 sb.checked, sb.n_ok);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("bitmap_page_allocator_top test passed");
        else
            $display("bitmap_page_allocator_top test failed");
        $finish;
    end
endmodule
